/* rtl/tfn_pkg.sv */
package tfn_pkg;

    localparam int COORD_BITS       = 24;
    localparam int NORMAL_FRAC_BITS = 15;

    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int MAG_W      = PROD_W + 1;
    localparam int LEN_W      = $clog2(MAG_W + 1);
    // the largest scaled magnitude keeps its leading one at bit 30
    localparam int M_W        = 31;
    localparam int SQ_W       = 2 * M_W;
    localparam int S_W        = 64;
    localparam int R_W        = S_W / 2;
    localparam int SQRT_STEPS = S_W / 2;
    localparam int OUT_W      = NORMAL_FRAC_BITS + 1;
    localparam int Q_W        = NORMAL_FRAC_BITS + 1;
    localparam int N_W        = M_W + NORMAL_FRAC_BITS + 1;
    localparam int LATENCY    = 4 + 4 + SQRT_STEPS + 1 + Q_W + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
        logic       last;
    } t_side;

endpackage

/* rtl/triangle_flat_normal_core.sv */
// Flat face normal of a triangle. A transaction is accepted on every clock edge with start
// high; busy is always low, so a new triangle may follow in the very next cycle. Each
// triangle produces exactly one result, shown for one cycle with o_done high, after
// it passes edge and cross product, block scaling and sum of squares, the one-bit-per-stage
// square root, rounding setup, the one-bit-per-stage divider and saturation, in that
// order. Results leave in input order. The receiver cannot stall the block, so it must
// take every o_done cycle. A zero cross product gives a zero normal with o_degenerate high.
module triangle_flat_normal_core
    import tfn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  t_coord                  i_first_x,
    input  t_coord                  i_first_y,
    input  t_coord                  i_first_z,
    input  t_coord                  i_second_x,
    input  t_coord                  i_second_y,
    input  t_coord                  i_second_z,
    input  t_coord                  i_third_x,
    input  t_coord                  i_third_y,
    input  t_coord                  i_third_z,
    input  logic                    i_last_triangle,
    output logic                    o_done,
    output logic signed [OUT_W-1:0] o_normal_x,
    output logic signed [OUT_W-1:0] o_normal_y,
    output logic signed [OUT_W-1:0] o_normal_z,
    output logic                    o_degenerate,
    output logic                    o_last_out
);

    t_coord first  [3];
    t_coord second [3];
    t_coord third  [3];

    // cross product stage outputs
    logic             cr_valid;
    logic [MAG_W-1:0] cr_mag [3];
    t_side            cr_side;

    // block scaling outputs
    logic             sc_valid;
    logic [S_W-1:0]   sc_sum;
    logic [M_W-1:0]   sc_m [3];
    t_side            sc_side;

    // square root outputs
    logic             sq_valid;
    logic [R_W-1:0]   sq_root;
    logic [M_W-1:0]   sq_m [3];
    t_side            sq_side;

    logic signed [OUT_W-1:0] dv_n [3];
    t_side                   dv_side;

    // the pipeline never holds off a transaction
    assign busy = 1'b0;

    assign first  = '{i_first_x, i_first_y, i_first_z};
    assign second = '{i_second_x, i_second_y, i_second_z};
    assign third  = '{i_third_x, i_third_y, i_third_z};

    tfn_cross u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_first  (first),
        .i_second (second),
        .i_third  (third),
        .i_last   (i_last_triangle),
        .o_valid  (cr_valid),
        .o_mag    (cr_mag),
        .o_side   (cr_side)
    );

    // leading-one search, shift to bit 30, sum of squares
    tfn_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cr_valid),
        .i_mag   (cr_mag),
        .i_side  (cr_side),
        .o_valid (sc_valid),
        .o_sum   (sc_sum),
        .o_m     (sc_m),
        .o_side  (sc_side)
    );

    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sc_valid),
        .i_sum   (sc_sum),
        .i_m     (sc_m),
        .i_side  (sc_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_m     (sq_m),
        .o_side  (sq_side)
    );

    // rounded division by the root, then saturation to q1.15
    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_m     (sq_m),
        .i_side  (sq_side),
        .o_valid (o_done),
        .o_n     (dv_n),
        .o_side  (dv_side)
    );

    assign o_normal_x   = dv_n[0];
    assign o_normal_y   = dv_n[1];
    assign o_normal_z   = dv_n[2];
    assign o_degenerate = dv_side.deg;
    assign o_last_out   = dv_side.last;

endmodule

/* rtl/tfn_cross.sv */
module tfn_cross
    import tfn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_coord           i_first  [3],
    input  t_coord           i_second [3],
    input  t_coord           i_third  [3],
    input  logic             i_last,
    output logic             o_valid,
    output logic [MAG_W-1:0] o_mag [3],
    output t_side            o_side
);

    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [PROD_W-1:0] r_p  [6];
    logic signed [MAG_W-1:0]  r_c  [3];
    logic [MAG_W-1:0]         r_mag [3];
    logic [3:0]               r_v;
    t_side                    r_side [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // edges
        for (int i = 0; i < 3; i++) begin
            r_e1[i] <= EDGE_W'(i_third[i]) - EDGE_W'(i_second[i]);
            r_e2[i] <= EDGE_W'(i_first[i]) - EDGE_W'(i_second[i]);
        end
        r_side[0] <= '{neg: 3'b000, deg: 1'b0, last: i_last};
        // partial products of the cross product
        r_p[0] <= PROD_W'(r_e1[1]) * PROD_W'(r_e2[2]);
        r_p[1] <= PROD_W'(r_e1[2]) * PROD_W'(r_e2[1]);
        r_p[2] <= PROD_W'(r_e1[2]) * PROD_W'(r_e2[0]);
        r_p[3] <= PROD_W'(r_e1[0]) * PROD_W'(r_e2[2]);
        r_p[4] <= PROD_W'(r_e1[0]) * PROD_W'(r_e2[1]);
        r_p[5] <= PROD_W'(r_e1[1]) * PROD_W'(r_e2[0]);
        r_side[1] <= r_side[0];
        for (int i = 0; i < 3; i++) begin
            r_c[i] <= MAG_W'(r_p[2*i]) - MAG_W'(r_p[2*i+1]);
        end
        r_side[2] <= r_side[1];
        // sign and magnitude
        r_side[3] <= '{neg:  {r_c[2][MAG_W-1], r_c[1][MAG_W-1], r_c[0][MAG_W-1]},
                       deg:  r_side[2].deg,
                       last: r_side[2].last};
        for (int i = 0; i < 3; i++) begin
            r_mag[i] <= r_c[i][MAG_W-1] ? MAG_W'(-r_c[i]) : MAG_W'(r_c[i]);
        end
    end

    assign o_valid = r_v[3];
    assign o_mag   = r_mag;
    assign o_side  = r_side[3];

endmodule

/* rtl/tfn_scale.sv */
module tfn_scale
    import tfn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [MAG_W-1:0] i_mag [3],
    input  t_side            i_side,
    output logic             o_valid,
    output logic [S_W-1:0]   o_sum,
    output logic [M_W-1:0]   o_m [3],
    output t_side            o_side
);

    logic [MAG_W-1:0]     orv;
    logic [LEN_W-1:0]     len;
    logic [MAG_W-1:0]     r_mag [3];
    logic [LEN_W-1:0]     r_len;
    logic [MAG_W+M_W-1:0] shv [3];
    logic [M_W-1:0]       r_m  [3];
    logic [M_W-1:0]       r_m2 [3];
    logic [M_W-1:0]       r_m3 [3];
    logic [SQ_W-1:0]      r_sq [3];
    logic [S_W-1:0]       r_sum;
    logic [3:0]           r_v;
    t_side                r_side [4];

    // leading one of the largest magnitude
    always_comb begin
        orv = i_mag[0] | i_mag[1] | i_mag[2];
        len = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (orv[b]) len = LEN_W'(b + 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shv[i] = {r_mag[i], M_W'(0)} >> r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= i_mag;
        r_len     <= len;
        r_side[0] <= '{neg: i_side.neg, deg: (len == '0), last: i_side.last};
        for (int i = 0; i < 3; i++) begin
            r_m[i] <= shv[i][M_W-1:0];
        end
        r_side[1] <= r_side[0];
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= SQ_W'(r_m[i]) * SQ_W'(r_m[i]);
        end
        r_m2      <= r_m;
        r_side[2] <= r_side[1];
        r_sum     <= S_W'(r_sq[0]) + S_W'(r_sq[1]) + S_W'(r_sq[2]);
        r_m3      <= r_m2;
        r_side[3] <= r_side[2];
    end

    assign o_valid = r_v[3];
    assign o_sum   = r_sum;
    assign o_m     = r_m3;
    assign o_side  = r_side[3];

endmodule

/* rtl/tfn_sqrt.sv */
module tfn_sqrt
    import tfn_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [S_W-1:0] i_sum,
    input  logic [M_W-1:0] i_m [3],
    input  t_side          i_side,
    output logic           o_valid,
    output logic [R_W-1:0] o_root,
    output logic [M_W-1:0] o_m [3],
    output t_side          o_side
);

    // stage k reads x_*[k] and writes r_*[k+1]
    logic           x_v [SQRT_STEPS];
    logic [S_W-1:0] x_s [SQRT_STEPS];
    logic [S_W-1:0] x_r [SQRT_STEPS];
    logic [M_W-1:0] x_m [SQRT_STEPS][3];
    t_side          x_side [SQRT_STEPS];

    logic           r_v [1:SQRT_STEPS];
    logic [S_W-1:0] r_s [1:SQRT_STEPS];
    logic [S_W-1:0] r_r [1:SQRT_STEPS];
    logic [M_W-1:0] r_m [1:SQRT_STEPS][3];
    t_side          r_side [1:SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [S_W-1:0] BIT = S_W'(1) << (S_W - 2 - 2*k);
        logic [S_W-1:0] trial;

        if (k == 0) begin : g_head
            assign x_v[k]    = i_valid;
            assign x_s[k]    = i_sum;
            assign x_r[k]    = '0;
            assign x_m[k]    = i_m;
            assign x_side[k] = i_side;
        end else begin : g_body
            assign x_v[k]    = r_v[k];
            assign x_s[k]    = r_s[k];
            assign x_r[k]    = r_r[k];
            assign x_m[k]    = r_m[k];
            assign x_side[k] = r_side[k];
        end

        assign trial = x_r[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= x_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (x_s[k] >= trial) begin
                r_s[k+1] <= x_s[k] - trial;
                r_r[k+1] <= (x_r[k] >> 1) + BIT;
            end else begin
                r_s[k+1] <= x_s[k];
                r_r[k+1] <= x_r[k] >> 1;
            end
            r_m[k+1]    <= x_m[k];
            r_side[k+1] <= x_side[k];
        end
    end

    assign o_valid = r_v[SQRT_STEPS];
    assign o_root  = r_r[SQRT_STEPS][R_W-1:0];
    assign o_m     = r_m[SQRT_STEPS];
    assign o_side  = r_side[SQRT_STEPS];

endmodule

/* rtl/tfn_div.sv */
module tfn_div
    import tfn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [R_W-1:0]          i_root,
    input  logic [M_W-1:0]          i_m [3],
    input  t_side                   i_side,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_n [3],
    output t_side                   o_side
);

    localparam logic [Q_W-1:0] ONE = Q_W'(1) << NORMAL_FRAC_BITS;

    // index 0 holds the rounded dividend, index j+1 the state after quotient step j
    logic           r_v    [0:Q_W];
    logic [N_W-1:0] r_rem  [0:Q_W][3];
    logic [Q_W-1:0] r_q    [0:Q_W][3];
    logic [R_W-1:0] r_root [0:Q_W];
    t_side          r_side [0:Q_W];

    logic                    r_ov;
    logic signed [OUT_W-1:0] r_n [3];
    t_side                   r_oside;
    logic [Q_W-1:0]          qs [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_rem[0][i] <= (N_W'(i_m[i]) << NORMAL_FRAC_BITS) + N_W'(i_root >> 1);
            r_q[0][i]   <= '0;
        end
        r_root[0] <= i_root;
        r_side[0] <= i_side;
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int B = Q_W - 1 - j;
        logic [N_W-1:0] d;

        assign d = N_W'(r_root[j]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rem[j][i] >= d) begin
                    r_rem[j+1][i] <= r_rem[j][i] - d;
                    r_q[j+1][i]   <= r_q[j][i] | (Q_W'(1) << B);
                end else begin
                    r_rem[j+1][i] <= r_rem[j][i];
                    r_q[j+1][i]   <= r_q[j][i];
                end
            end
            r_root[j+1] <= r_root[j];
            r_side[j+1] <= r_side[j];
        end
    end

    // saturate and apply sign
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_side[Q_W].neg[i]) begin
                qs[i] = (r_q[Q_W][i] > ONE) ? ONE : r_q[Q_W][i];
            end else begin
                qs[i] = (r_q[Q_W][i] > ONE - 1'b1) ? ONE - 1'b1 : r_q[Q_W][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_side[Q_W].deg) begin
                r_n[i] <= '0;
            end else if (r_side[Q_W].neg[i]) begin
                r_n[i] <= OUT_W'(-qs[i]);
            end else begin
                r_n[i] <= OUT_W'(qs[i]);
            end
        end
        r_oside <= r_side[Q_W];
    end

    assign o_valid = r_ov;
    assign o_n     = r_n;
    assign o_side  = r_oside;

endmodule

/* rtl/tfn_checker.sv */
module tfn_checker
    import tfn_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input t_coord                  i_first_x,
    input t_coord                  i_first_y,
    input t_coord                  i_first_z,
    input t_coord                  i_second_x,
    input t_coord                  i_second_y,
    input t_coord                  i_second_z,
    input t_coord                  i_third_x,
    input t_coord                  i_third_y,
    input t_coord                  i_third_z,
    input logic                    i_last_triangle,
    input logic                    o_done,
    input logic signed [OUT_W-1:0] o_normal_x,
    input logic signed [OUT_W-1:0] o_normal_y,
    input logic signed [OUT_W-1:0] o_normal_z,
    input logic                    o_degenerate,
    input logic                    o_last_out
);

    a_never_busy : assert property (@(posedge i_clk) !busy)
        else $error("busy raised");

    a_reset_quiet : assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result right after reset");

    a_degenerate_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_degenerate |-> o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
        else $error("degenerate with nonzero normal");

    a_normal_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_degenerate |-> o_normal_x != '0 || o_normal_y != '0 || o_normal_z != '0)
        else $error("zero normal without degenerate flag");

endmodule

bind triangle_flat_normal_core tfn_checker u_tfn_checker (.*);

/* test/testbench.sv */
module testbench;
    import tfn_pkg::*;

    // one triangle as driven on the input ports
    typedef struct {
        t_coord v [9];  // first xyz, second xyz, third xyz
        logic   last;
    } t_tri;

    // one face normal as seen on the result ports
    typedef struct {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    deg;
        logic                    last;
    } t_normal;

    // directed row: triangle plus an optional hand-typed normal
    typedef struct {
        t_tri    face;
        logic    typed;
        t_normal nrm;
    } t_row;

    localparam t_coord C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] N_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] N_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_coord i_first_x, i_first_y, i_first_z;
    t_coord i_second_x, i_second_y, i_second_z;
    t_coord i_third_x, i_third_y, i_third_z;
    logic i_last_triangle;
    logic o_done;
    logic signed [OUT_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate;
    logic o_last_out;

    t_normal pending_normals [$];
    t_row    face_table [$];
    int      errors = 0;

    triangle_flat_normal_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_first_x       (i_first_x),
        .i_first_y       (i_first_y),
        .i_first_z       (i_first_z),
        .i_second_x      (i_second_x),
        .i_second_y      (i_second_y),
        .i_second_z      (i_second_z),
        .i_third_x       (i_third_x),
        .i_third_y       (i_third_y),
        .i_third_z       (i_third_z),
        .i_last_triangle (i_last_triangle),
        .o_done          (o_done),
        .o_normal_x      (o_normal_x),
        .o_normal_y      (o_normal_y),
        .o_normal_z      (o_normal_z),
        .o_degenerate    (o_degenerate),
        .o_last_out      (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int bit_length(input longint unsigned v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 1;
        end
        return n;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // edges, exact cross product, block scaling to bit 30, sqrt, rounded divide
    function automatic t_normal face_normal(input t_tri t);
        longint e1 [3], e2 [3], c [3];
        longint unsigned m [3], s, r, q, one;
        logic neg [3];
        logic signed [OUT_W-1:0] o [3];
        int maxlen, sh;
        t_normal n;
        one = 64'd1 << NORMAL_FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(t.v[6+i]) - longint'(t.v[3+i]);
            e2[i] = longint'(t.v[i]) - longint'(t.v[3+i]);
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        maxlen = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = c[i] < 0;
            m[i] = neg[i] ? -c[i] : c[i];
            if (bit_length(m[i]) > maxlen) maxlen = bit_length(m[i]);
        end
        n.last = t.last;
        if (maxlen == 0) begin
            n.nx = '0; n.ny = '0; n.nz = '0; n.deg = 1'b1;
            return n;
        end
        sh = 31 - maxlen;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (sh >= 0) ? (m[i] << sh) : (m[i] >> (-sh));
            s += m[i] * m[i];
        end
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << NORMAL_FRAC_BITS) + (r >> 1)) / r;
            if (neg[i]) begin
                if (q > one) q = one;
                o[i] = OUT_W'(-q);
            end else begin
                if (q > one - 1) q = one - 1;
                o[i] = OUT_W'(q);
            end
        end
        n.nx = o[0]; n.ny = o[1]; n.nz = o[2]; n.deg = 1'b0;
        return n;
    endfunction

    function automatic t_tri make_tri(input t_coord ax, ay, az, bx, by, bz, cx, cy, cz,
                                      input logic lst);
        t_tri t;
        t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        t.last = lst;
        return t;
    endfunction

    task automatic add_row(input t_tri t, input logic typed, input t_normal n = '{0, 0, 0, 0, 0});
        t_row r;
        r.face = t;
        r.typed = typed;
        r.nrm = n;
        r.nrm.last = t.last;
        face_table.push_back(r);
    endtask

    function automatic t_coord rand_coord(input int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? C_MAX : C_MIN;
            default: return t_coord'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int mode, kind;
        mode = $urandom_range(0, 9);
        mode = (mode < 5) ? 0 : (mode < 7) ? 3 : (mode < 9) ? 1 : 2;
        for (int i = 0; i < 9; i++) t.v[i] = rand_coord(mode);
        kind = $urandom_range(0, 19);
        // occasionally a repeated vertex or a collinear third vertex
        if (kind == 0) begin
            for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
        end else if (kind == 1) begin
            for (int i = 0; i < 3; i++) t.v[i] = t.v[3+i];
        end else if (kind == 2) begin
            for (int i = 0; i < 3; i++) begin
                t.v[i] = rand_coord(1);
                t.v[3+i] = rand_coord(1);
                t.v[6+i] = t_coord'(t.v[3+i] + 2 * (t.v[i] - t.v[3+i]));
            end
        end
        t.last = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // one transaction; start stays high while back-to-back
    task automatic send_triangle(input t_tri t);
        start <= 1'b1;
        {i_first_x, i_first_y, i_first_z} <= {t.v[0], t.v[1], t.v[2]};
        {i_second_x, i_second_y, i_second_z} <= {t.v[3], t.v[4], t.v[5]};
        {i_third_x, i_third_y, i_third_z} <= {t.v[6], t.v[7], t.v[8]};
        i_last_triangle <= t.last;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // burst length, and a gap once each burst is used up
    int burst_left = 0;
    task automatic sender_gap();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
            idle_cycles($urandom_range(1, 6));
        end
    endtask

    // expectation is queued at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            t_tri t;
            t.v = '{i_first_x, i_first_y, i_first_z, i_second_x, i_second_y, i_second_z,
                    i_third_x, i_third_y, i_third_z};
            t.last = i_last_triangle;
            pending_normals.push_back(face_normal(t));
        end
    end

    // result checker; results cannot be held off so every strobe is taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_normals.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                t_normal w;
                w = pending_normals.pop_front();
                if (o_normal_x !== w.nx) report("normal_x", o_normal_x, w.nx);
                if (o_normal_y !== w.ny) report("normal_y", o_normal_y, w.ny);
                if (o_normal_z !== w.nz) report("normal_z", o_normal_z, w.nz);
                if (o_degenerate !== w.deg) report("degenerate", o_degenerate, w.deg);
                if (o_last_out !== w.last) report("last_out", o_last_out, w.last);
            end
        end
    end

    // hand-typed rows are also checked directly against the strobe stream
    t_normal typed_normals [$];
    logic    typed_flags [$];
    always @(posedge i_clk) begin
        if (i_rst_n && o_done && typed_flags.size() != 0) begin
            logic f;
            t_normal w;
            f = typed_flags.pop_front();
            w = typed_normals.pop_front();
            if (f && {o_normal_x, o_normal_y, o_normal_z, o_degenerate, o_last_out}
                     !== {w.nx, w.ny, w.nz, w.deg, w.last})
                report("typed normal", o_normal_z, w.nz);
        end
    end

    initial begin
        t_tri z;
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_first_x, i_first_y, i_first_z} = '0;
        {i_second_x, i_second_y, i_second_z} = '0;
        {i_third_x, i_third_y, i_third_z} = '0;
        i_last_triangle = 1'b0;

        // all-zero triangle: degenerate, zero normal
        add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1, 0});
        // repeated vertex, with last set
        add_row(make_tri(5, 6, 7, 5, 6, 7, -3, 2, 9, 1), 1, '{0, 0, 0, 1, 1});
        // unit edges on x and y: normal along +z, +1.0 saturates
        add_row(make_tri(0, 1, 0, 0, 0, 0, 1, 0, 0, 0), 1, '{0, 0, N_POS, 0, 0});
        // mirrored: normal along -z, exactly -1.0
        add_row(make_tri(0, -1, 0, 0, 0, 0, 1, 0, 0, 1), 1, '{0, 0, N_NEG, 0, 0});
        add_row(make_tri(0, 0, 1, 0, 0, 0, 0, 1, 0, 0), 1, '{N_POS, 0, 0, 0, 0});
        add_row(make_tri(1, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, '{0, N_POS, 0, 0, 0});
        // collinear points along a line
        add_row(make_tri(2, 4, 6, 1, 2, 3, 3, 6, 9, 0), 1, '{0, 0, 0, 1, 0});
        // extremes of the coordinate range, checked by the predictor
        add_row(make_tri(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, 1), 0);
        add_row(make_tri(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 0), 0);
        add_row(make_tri(C_MAX, 0, 0, C_MIN, 0, 0, 0, C_MAX, C_MIN, 1), 0);
        add_row(make_tri(C_MIN, C_MIN, 0, C_MAX, C_MAX, 0, C_MIN, C_MAX, C_MAX, 0), 0);
        add_row(make_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0), 1,
                '{0, 0, 0, 1, 0});
        add_row(make_tri(1, 0, 0, 0, 0, 0, 0, 1, 0, 1), 0);
        add_row(make_tri(C_MAX, 1, 0, 0, 0, 0, 1, C_MAX, 0, 0), 0);
        add_row(make_tri(-1, -1, 1, 0, 0, 0, 1, -1, -1, 1), 0);
        add_row(make_tri(3, 0, 0, 0, 0, 0, 0, 4, 0, 0), 0);
        add_row(make_tri(4096, 0, -4096, -4096, 4096, 0, 0, -4096, 4096, 1), 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (face_table[k]) begin
            typed_flags.push_back(face_table[k].typed);
            typed_normals.push_back(face_table[k].nrm);
            send_triangle(face_table[k].face);
            if (k % 5 == 4) idle_cycles($urandom_range(1, 4));
        end

        for (int k = 0; k < 800; k++) begin
            send_triangle(rand_tri());
            sender_gap();
            // drain the pipe once mid-run
            if (k == 400) begin
                start <= 1'b0;
                while (pending_normals.size() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        while (pending_normals.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
